>>> hw/rtl/safd_pkg.sv
package safd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned DataW     = 7;
  localparam int unsigned AngleW    = 23;
  localparam int unsigned StoreDepth = 10;
  localparam int unsigned CountW    = 4;

  localparam logic [ByteW-1:0]  StartByte  = 8'h80;
  localparam logic [ByteW-1:0]  EndByte    = 8'h90;
  localparam logic [CountW-1:0] StoreLimit = 4'd10;
  localparam logic [CountW-1:0] CountLimit = 4'd11;
  localparam logic [CountW-1:0] MsbIndex   = 4'd9;

  typedef logic [StoreDepth-1:0][DataW-1:0] store_t;

  typedef struct packed {
    logic [AngleW-1:0] angle_a;
    logic [AngleW-1:0] angle_b;
    logic [AngleW-1:0] angle_c;
  } angles_t;

  typedef struct packed {
    logic    valid;
    angles_t angles;
  } result_t;

  // low byte and middle byte get their restored bit 7, top byte stays 7 bits
  function automatic logic [AngleW-1:0] build_angle(
    input logic [DataW-1:0] b0,
    input logic [DataW-1:0] b1,
    input logic [DataW-1:0] b2,
    input logic             lo_msb,
    input logic             mid_msb
  );
    build_angle = {b2, mid_msb, b1, lo_msb, b0};
  endfunction

endpackage

>>> hw/rtl/safd_byte_if.sv
interface safd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [safd_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/safd_angle_if.sv
interface safd_angle_if;
  logic                        valid;
  logic                        ready;
  logic [safd_pkg::AngleW-1:0] angle_a;
  logic [safd_pkg::AngleW-1:0] angle_b;
  logic [safd_pkg::AngleW-1:0] angle_c;

  modport source (output valid, output angle_a, output angle_b, output angle_c, input ready);
  modport sink (input valid, input angle_a, input angle_b, input angle_c, output ready);
endinterface

>>> hw/rtl/safd_frame.sv
module safd_frame (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [safd_pkg::ByteW-1:0] rx_byte,
  output safd_pkg::result_t          result
);

  logic                        in_frame;
  logic [safd_pkg::CountW-1:0] byte_count;
  safd_pkg::store_t            frame_store;

  logic [safd_pkg::CountW-1:0] count_inc;
  logic [safd_pkg::DataW-1:0]  msb;
  logic                        is_end;

  assign count_inc = byte_count + 1'b1;
  assign msb       = frame_store[safd_pkg::MsbIndex];
  assign is_end    = (rx_byte == safd_pkg::EndByte);

  always_comb begin
    result.valid          = take && in_frame && is_end;
    result.angles.angle_a = safd_pkg::build_angle(frame_store[0], frame_store[1],
                                                  frame_store[2], msb[0], msb[1]);
    result.angles.angle_b = safd_pkg::build_angle(frame_store[3], frame_store[4],
                                                  frame_store[5], msb[2], msb[3]);
    result.angles.angle_c = safd_pkg::build_angle(frame_store[6], frame_store[7],
                                                  frame_store[8], msb[4], msb[5]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else if (take) begin
      if (!in_frame) begin
        if (rx_byte == safd_pkg::StartByte) begin
          in_frame   <= 1'b1;
          byte_count <= '0;
        end
      end else if (rx_byte[safd_pkg::ByteW-1]) begin
        // end byte closes the frame, any other high byte aborts it
        in_frame <= 1'b0;
      end else begin
        byte_count <= count_inc;
        if (count_inc >= safd_pkg::CountLimit) begin
          in_frame <= 1'b0;
        end
      end
    end
  end

  // store needs no reset: every frame starts by clearing it
  always_ff @(posedge clk) begin
    if (take) begin
      if (!in_frame && rx_byte == safd_pkg::StartByte) begin
        frame_store <= '0;
      end else if (in_frame && !rx_byte[safd_pkg::ByteW-1] &&
                   byte_count < safd_pkg::StoreLimit) begin
        frame_store[byte_count] <= rx_byte[safd_pkg::DataW-1:0];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> byte_count < safd_pkg::CountLimit)
    else $error("byte count reached limit inside a frame");

  a_result_in_frame: assert property (@(posedge clk) disable iff (rst)
    result.valid |=> !in_frame)
    else $error("frame still open after end byte");

endmodule

>>> hw/rtl/safd_out_buf.sv
module safd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  safd_pkg::result_t  result,
  output logic               space,
  safd_angle_if.source       angles
);

  logic              out_valid;
  safd_pkg::angles_t out_data;
  logic              skid_valid;
  safd_pkg::angles_t skid_data;
  logic              pop;
  logic              push;

  assign pop   = out_valid && angles.ready;
  assign push  = result.valid;
  assign space = !skid_valid;

  assign angles.valid   = out_valid;
  assign angles.angle_a = out_data.angle_a;
  assign angles.angle_b = out_data.angle_b;
  assign angles.angle_c = out_data.angle_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= result.angles;
        end else begin
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        out_data <= result.angles;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= result.angles;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result.angles;
        skid_valid <= 1'b1;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data while output is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && skid_valid) |-> pop)
    else $error("result pushed into a full buffer");

endmodule

>>> hw/rtl/servo_angle_frame_deframer.sv
// an end byte registers its result into the output or else the skid stage
// throughput: one rx byte per cycle; rx stalls only while the skid stage
//   holds a second result that angles has not taken yet
// reset (rst, synchronous, active high): idle, waiting for a start byte,
//   output and skid stages empty
module servo_angle_frame_deframer (
  input  logic         clk,
  input  logic         rst,
  safd_byte_if.sink    rx,
  safd_angle_if.source angles
);

  safd_pkg::result_t result;
  logic              space;
  logic              take;

  // a byte transfer happens whenever rx is valid and the skid stage is free
  assign rx.ready = space;
  assign take     = rx.valid && space;

  // frame tracking, data store and angle assembly
  safd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .result  (result)
  );

  // output register plus skid stage decouples angles from rx
  safd_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .result (result),
    .space  (space),
    .angles (angles)
  );

endmodule

>>> verif/safd_angle_checker.sv
module safd_angle_checker
  import safd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  safd_byte_if  rx_mon,
  safd_angle_if ang_mon,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  // shadow of the deframer state
  logic              open_frame;
  logic [CountW-1:0] taken;
  logic [DataW-1:0]  held [StoreDepth];
  angles_t           expected_angles [$];

  // angle k uses stored bytes 3k..3k+2 and restored bits 2k, 2k+1 of the msb byte
  function automatic logic [AngleW-1:0] rebuild_angle(input int k);
    logic [7:0] lo;
    logic [7:0] mid;
    lo  = {held[MsbIndex][2*k], held[3*k]};
    mid = {held[MsbIndex][2*k+1], held[3*k+1]};
    return AngleW'({held[3*k+2], 16'b0}) | AngleW'({mid, 8'b0}) | AngleW'(lo);
  endfunction

  task automatic take_byte(input logic [ByteW-1:0] b);
    angles_t frame_out;
    if (!open_frame) begin
      if (b == StartByte) begin
        open_frame = 1'b1;
        taken      = '0;
        foreach (held[i]) held[i] = '0;
      end
    end else if (b == EndByte) begin
      open_frame        = 1'b0;
      frame_out.angle_a = rebuild_angle(0);
      frame_out.angle_b = rebuild_angle(1);
      frame_out.angle_c = rebuild_angle(2);
      expected_angles.push_back(frame_out);
    end else if (b[ByteW-1]) begin
      open_frame = 1'b0;
    end else begin
      if (taken < StoreLimit) held[taken] = b[DataW-1:0];
      taken = taken + 1'b1;
      if (taken >= CountLimit) open_frame = 1'b0;
    end
  endtask

  task automatic compare_field(input string name, input logic [AngleW-1:0] want,
                               input logic [AngleW-1:0] got);
    if (got !== want) begin
      if (fail_count < ReportLimit)
        $display("%s mismatch: expected %h got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    angles_t want;
    if (rst) begin
      open_frame = 1'b0;
      taken      = '0;
      foreach (held[i]) held[i] = '0;
      expected_angles.delete();
      fail_count = 0;
    end else begin
      if (ang_mon.valid && ang_mon.ready) begin
        if (expected_angles.size() == 0) begin
          if (fail_count < ReportLimit)
            $display("unexpected angle transfer: a %h b %h c %h",
                     ang_mon.angle_a, ang_mon.angle_b, ang_mon.angle_c);
          fail_count++;
        end else begin
          want = expected_angles.pop_front();
          compare_field("angle_a", want.angle_a, ang_mon.angle_a);
          compare_field("angle_b", want.angle_b, ang_mon.angle_b);
          compare_field("angle_c", want.angle_c, ang_mon.angle_c);
        end
      end
      if (rx_mon.valid && rx_mon.ready) take_byte(rx_mon.rx_byte);
    end
    pending <= expected_angles.size();
  end

endmodule

>>> verif/tb_servo_angle_frame_deframer.sv
module tb_servo_angle_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import safd_pkg::*;

  localparam int HoldCycles = 240;   // long receiver hold-off, fills output and skid
  localparam int SettleCycles = 4;   // idle time after the last predicted result has been taken
  localparam int PhaseItems = 240;   // minimum frame bytes per random phase, three phases

  logic clk;
  logic rst;
  logic rx_took = 1'b0;

  int src_idle_pct = 24;
  int snk_idle_pct = 80;
  int hold_requests = 0;
  int fail_count;
  int pending;

  safd_byte_if  rx ();
  safd_angle_if angles ();

  servo_angle_frame_deframer dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .angles (angles)
  );

  safd_angle_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .rx_mon     (rx),
    .ang_mon    (angles),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // byte transfer seen at the rising edge, read by the sender at the next falling edge
  always @(posedge clk) rx_took <= rx.valid && rx.ready;

  // overall limit far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("servo_angle_frame_deframer regression: fail");
    $finish;
  end

  // receiver: random ready, plus a counted hold-off whenever the sender asks for one
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    angles.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        angles.ready <= 1'b0;
      end else begin
        angles.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // offer one byte after a random gap, return at the falling edge after its transfer
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx.valid   <= 1'b0;
      rx.rx_byte <= ByteW'($urandom_range(0, 255));
      @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(negedge clk); while (!rx_took);
  endtask

  // stop offering until every predicted result has been taken, then let it settle
  task automatic drain_results();
    rx.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // mostly well-formed frames with random content; some overflow, some
  // cut short by a stray high byte, some preceded by idle noise
  task automatic run_random_frames(input int item_goal);
    int sent;
    int len;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] closer;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom_range(0, 255)));
      send_byte(StartByte);
      case ($urandom_range(0, 11))
        0:       len = 11;                      // overflow abort
        1, 2:    len = StoreDepth;              // full frame
        default: len = $urandom_range(0, StoreDepth);
      endcase
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 5))
          0:       data = 8'h00;
          1:       data = 8'h7f;
          default: data = ByteW'($urandom_range(0, 127));
        endcase
        send_byte(data);
      end
      // after an overflow the end byte lands on an idle deframer and is ignored
      if (len > StoreDepth || $urandom_range(0, 9) != 0)
        closer = EndByte;
      else
        closer = {1'b1, 7'($urandom_range(0, 127))};
      send_byte(closer);
      sent += len + 2;
    end
  endtask

  initial begin
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle deframer ignores data and end bytes
    send_byte(8'h00);
    send_byte(EndByte);
    // empty frame gives three zero angles
    send_byte(StartByte);
    send_byte(EndByte);
    // full frame of all-ones data, every restored bit set
    send_byte(StartByte);
    repeat (StoreDepth) send_byte(8'h7f);
    send_byte(EndByte);
    // short frame, missing bytes read as zero
    send_byte(StartByte);
    send_byte(8'h55);
    send_byte(8'h2a);
    send_byte(EndByte);
    // second start aborts without restart, so the end byte is ignored
    send_byte(StartByte);
    send_byte(StartByte);
    send_byte(EndByte);
    // other high byte inside a frame aborts it
    send_byte(StartByte);
    send_byte(8'h05);
    send_byte(8'ha5);
    drain_results();

    // slow receiver
    run_random_frames(PhaseItems);
    drain_results();

    // slow sender
    src_idle_pct <= 80;
    snk_idle_pct <= 24;
    run_random_frames(PhaseItems);
    drain_results();

    // full rate, with one long receiver hold-off so rx backs up
    src_idle_pct <= 0;
    snk_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    run_random_frames(PhaseItems);
    drain_results();

    if (fail_count == 0 && pending == 0)
      $display("servo_angle_frame_deframer regression: pass");
    else
      $display("servo_angle_frame_deframer regression: fail");
    $finish;
  end

endmodule
